/* hdl/order_book_best_price_tracker_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the order book best price tracker.
// ----------------------------------------------------------------------------
`ifndef ORDER_BOOK_BEST_PRICE_TRACKER_DEFINES_SVH
`define ORDER_BOOK_BEST_PRICE_TRACKER_DEFINES_SVH

// Asserts an implication on the rising clock edge, disabled during reset.
`define OBT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Asserts an implication on the next clock cycle, disabled during reset.
`define OBT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/obt_pkg.sv */
// ----------------------------------------------------------------------------
// obt_pkg
// Codes, constants and saturating helpers shared by the order book best price tracker.
// ----------------------------------------------------------------------------
`default_nettype none
package obt_pkg;

  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_UPDATE = 2'd2;
  localparam logic [1:0] ACT_PROBE  = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_UNDERFLOW = 2'd3;

  localparam logic [31:0] NO_PRICE = 32'd0;
  localparam logic [31:0] QTY_MAX  = 32'hFFFF_FFFF;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? QTY_MAX : s[31:0];
  endfunction

  function automatic logic [31:0] sat_sub(input logic [31:0] a, input logic [31:0] b);
    return (a > b) ? (a - b) : 32'd0;
  endfunction

endpackage
`default_nettype wire

/* hdl/order_book_best_price_tracker.sv */
// Each transaction searches the used levels of its side; an add of a new price
// appends a level, and emptying the best level rescans the side for a new best.
// One transaction is in work at a time; the next is taken once the result is.
// Reset clears the level counts and best prices; no memory clearing pass.
// ----------------------------------------------------------------------------
// order_book_best_price_tracker
// Tracks best bid and ask over per-side price level tables held in RAM.
// ----------------------------------------------------------------------------
`default_nettype none
module order_book_best_price_tracker #(
  parameter int LEVEL_SLOTS = 256,
  parameter int COUNT_BITS  = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_action,
  input  wire logic        in_side,
  input  wire logic [31:0] in_price,
  input  wire logic [31:0] in_quantity,
  input  wire logic [31:0] in_old_quantity,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_bid_valid,
  output logic [31:0]      out_top_bid,
  output logic             out_ask_valid,
  output logic [31:0]      out_top_ask,
  output logic             out_crosses,
  output logic [15:0]      out_level_orders,
  output logic [31:0]      out_level_quantity,
  output logic [1:0]       out_status
);

  localparam int AW = (LEVEL_SLOTS > 1) ? $clog2(LEVEL_SLOTS) : 1;
  localparam int UW = $clog2(LEVEL_SLOTS + 1);
  localparam int EW = 32 + COUNT_BITS + 32;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [UW-1:0] SLOTS_U = UW'(LEVEL_SLOTS);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SRCH   = 7'b0000010,
    S_SCHK   = 7'b0000100,
    S_MOD    = 7'b0001000,
    S_SCAN   = 7'b0010000,
    S_SCHKR  = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [1:0]        act_r;
  logic              side_r;
  logic [31:0]       price_r, qty_r, oqty_r;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic [UW-1:0]     bid_used_r, ask_used_r;
  logic [31:0]       top_bid_r, top_ask_r;
  logic              bid_have_r, ask_have_r;
  logic [AW-1:0]     bid_slot_r, ask_slot_r;
  logic              scan_have_r;
  logic [31:0]       scan_best_r;
  logic [AW-1:0]     scan_slot_r;
  logic              cross_r;

  logic              o_valid_r;
  logic [15:0]       o_orders_r;
  logic [31:0]       o_qty_r;
  logic [1:0]        o_status_r;

  logic              we_bid, we_ask;
  logic [AW-1:0]     addr;
  logic [EW-1:0]     wdata, rd_bid, rd_ask, rd;

  obt_ram #(.WIDTH(EW), .DEPTH(LEVEL_SLOTS)) u_bid_ram (
    .clk(clk), .we(we_bid), .addr(addr), .wdata(wdata), .rdata(rd_bid)
  );
  obt_ram #(.WIDTH(EW), .DEPTH(LEVEL_SLOTS)) u_ask_ram (
    .clk(clk), .we(we_ask), .addr(addr), .wdata(wdata), .rdata(rd_ask)
  );

  logic [31:0]           rd_price, rd_total;
  logic [COUNT_BITS-1:0] rd_count;
  assign rd = side_r ? rd_ask : rd_bid;
  assign rd_price = rd[EW-1 -: 32];
  assign rd_count = rd[32 +: COUNT_BITS];
  assign rd_total = rd[31:0];

  logic [UW-1:0] used;
  assign used = side_r ? ask_used_r : bid_used_r;
  logic last_idx;
  assign last_idx = (UW'(idx_r) + UW'(1)) >= used;

  logic [31:0]           n_total;
  logic [COUNT_BITS-1:0] n_count;
  logic                  leaves;
  logic                  we;

  assign in_ready  = (state_r == S_IDLE) && (!o_valid_r || out_ready);
  assign out_valid = o_valid_r;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    addr      = idx_r;
    we        = 1'b0;
    wdata     = rd;
    leaves    = (act_r == obt_pkg::ACT_REMOVE)
                || (act_r == obt_pkg::ACT_UPDATE && qty_r == 32'd0);
    n_count   = rd_count;
    n_total   = rd_total;
    case (act_r)
      obt_pkg::ACT_ADD: begin
        n_count = (rd_count < CNT_MAX) ? rd_count + COUNT_BITS'(1) : rd_count;
        n_total = obt_pkg::sat_add(rd_total, qty_r);
      end
      obt_pkg::ACT_REMOVE: begin
        n_count = rd_count - COUNT_BITS'(1);
        n_total = obt_pkg::sat_sub(rd_total, qty_r);
      end
      obt_pkg::ACT_UPDATE: begin
        n_count = (qty_r == 32'd0) ? rd_count - COUNT_BITS'(1) : rd_count;
        n_total = obt_pkg::sat_add(obt_pkg::sat_sub(rd_total, oqty_r), qty_r);
      end
      default: begin
        n_count = rd_count;
        n_total = rd_total;
      end
    endcase
    if (state_r == S_MOD) begin
      if (new_lvl_r) begin
        wdata = {price_r, COUNT_BITS'(1), qty_r};
        we    = 1'b1;
      end else begin
        wdata = {price_r, n_count, n_total};
        we    = (act_r != obt_pkg::ACT_PROBE) && !(leaves && rd_count == '0);
      end
    end
    we_bid = we && !side_r;
    we_ask = we && side_r;
  end

  logic new_lvl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      o_valid_r   <= 1'b0;
      bid_used_r  <= '0;
      ask_used_r  <= '0;
      top_bid_r   <= '0;
      top_ask_r   <= '0;
      bid_have_r  <= 1'b0;
      ask_have_r  <= 1'b0;
      bid_slot_r  <= '0;
      ask_slot_r  <= '0;
      idx_r       <= '0;
      new_lvl_r   <= 1'b0;
    end else begin
      if (o_valid_r && out_ready) begin
        o_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            act_r   <= in_action;
            side_r  <= in_side;
            price_r <= in_price;
            qty_r   <= in_quantity;
            oqty_r  <= in_old_quantity;
            cross_r <= in_side ? (bid_have_r && in_price <= top_bid_r)
                               : (ask_have_r && in_price >= top_ask_r);
            idx_r   <= '0;
            new_lvl_r <= 1'b0;
            state_r <= S_SRCH;
          end
        end
        S_SRCH: begin
          state_r <= S_SCHK;
        end
        S_SCHK: begin
          if (used != '0 && rd_price == price_r) begin
            state_r <= S_MOD;
          end else if (used == '0 || last_idx) begin
            if (act_r != obt_pkg::ACT_ADD) begin
              o_status_r <= obt_pkg::ST_NOT_FOUND;
              o_orders_r <= '0;
              o_qty_r    <= '0;
              state_r    <= S_OUT;
            end else if (used >= SLOTS_U) begin
              o_status_r <= obt_pkg::ST_FULL;
              o_orders_r <= '0;
              o_qty_r    <= '0;
              state_r    <= S_OUT;
            end else begin
              idx_r     <= AW'(used);
              new_lvl_r <= 1'b1;
              if (side_r) ask_used_r <= ask_used_r + UW'(1);
              else bid_used_r <= bid_used_r + UW'(1);
              state_r   <= S_MOD;
            end
          end else begin
            idx_r   <= idx_r + AW'(1);
            state_r <= S_SRCH;
          end
        end
        S_MOD: begin
          state_r <= S_OUT;
          if (new_lvl_r) begin
            o_status_r <= obt_pkg::ST_OK;
            o_orders_r <= 16'(32'(1));
            o_qty_r    <= qty_r;
          end else if (act_r != obt_pkg::ACT_PROBE && leaves && rd_count == '0) begin
            o_status_r <= obt_pkg::ST_UNDERFLOW;
            o_orders_r <= 16'(rd_count);
            o_qty_r    <= rd_total;
          end else begin
            o_status_r <= obt_pkg::ST_OK;
            o_orders_r <= 16'(n_count);
            o_qty_r    <= n_total;
            if (act_r != obt_pkg::ACT_ADD && act_r != obt_pkg::ACT_PROBE && leaves
                && n_count == '0
                && (side_r ? (ask_have_r && ask_slot_r == idx_r)
                           : (bid_have_r && bid_slot_r == idx_r))) begin
              scan_have_r <= 1'b0;
              scan_best_r <= '0;
              scan_slot_r <= '0;
              idx_r       <= '0;
              state_r     <= S_SCAN;
            end
          end
          if (act_r == obt_pkg::ACT_ADD) begin
            if (side_r) begin
              if (!ask_have_r || price_r < top_ask_r) begin
                ask_have_r <= 1'b1; top_ask_r <= price_r; ask_slot_r <= idx_r;
              end
            end else begin
              if (!bid_have_r || price_r > top_bid_r) begin
                bid_have_r <= 1'b1; top_bid_r <= price_r; bid_slot_r <= idx_r;
              end
            end
          end
        end
        S_SCAN: begin
          state_r <= S_SCHKR;
        end
        S_SCHKR: begin
          if (rd_count != '0 && (!scan_have_r ||
              (side_r ? rd_price < scan_best_r : rd_price > scan_best_r))) begin
            scan_have_r <= 1'b1;
            scan_best_r <= rd_price;
            scan_slot_r <= idx_r;
          end
          if (last_idx) begin
            state_r <= S_OUT;
            if (side_r) begin
              if (rd_count != '0 && (!scan_have_r || rd_price < scan_best_r)) begin
                ask_have_r <= 1'b1; top_ask_r <= rd_price; ask_slot_r <= idx_r;
              end else begin
                ask_have_r <= scan_have_r;
                top_ask_r  <= scan_have_r ? scan_best_r : '0;
                ask_slot_r <= scan_have_r ? scan_slot_r : '0;
              end
            end else begin
              if (rd_count != '0 && (!scan_have_r || rd_price > scan_best_r)) begin
                bid_have_r <= 1'b1; top_bid_r <= rd_price; bid_slot_r <= idx_r;
              end else begin
                bid_have_r <= scan_have_r;
                top_bid_r  <= scan_have_r ? scan_best_r : '0;
                bid_slot_r <= scan_have_r ? scan_slot_r : '0;
              end
            end
          end else begin
            idx_r   <= idx_r + AW'(1);
            state_r <= S_SCAN;
          end
        end
        S_OUT: begin
          if (!o_valid_r || out_ready) begin
            o_valid_r <= 1'b1;
            state_r   <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_crosses        = cross_r;
  assign out_bid_valid      = bid_have_r;
  assign out_top_bid        = bid_have_r ? top_bid_r : obt_pkg::NO_PRICE;
  assign out_ask_valid      = ask_have_r;
  assign out_top_ask        = ask_have_r ? top_ask_r : obt_pkg::NO_PRICE;
  assign out_level_orders   = o_orders_r;
  assign out_level_quantity = o_qty_r;
  assign out_status         = o_status_r;

endmodule
`default_nettype wire

/* hdl/obt_ram.sv */
// ----------------------------------------------------------------------------
// obt_ram
// Generic single-port RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module obt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

/* hdl/obt_checker.sv */
// ----------------------------------------------------------------------------
// obt_checker
// Port-level assertions for the order book best price tracker.
// ----------------------------------------------------------------------------
`default_nettype none
`include "order_book_best_price_tracker_defines.svh"
module obt_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_bid_valid,
  input wire logic [31:0] out_top_bid,
  input wire logic        out_ask_valid,
  input wire logic [31:0] out_top_ask,
  input wire logic [1:0]  out_status
);

  `OBT_ASSERT_IMPL(a_no_bid_zero, clk, rst_n, out_valid && !out_bid_valid,
    out_top_bid == 32'd0, "best bid not zero without a bid")
  `OBT_ASSERT_IMPL(a_no_ask_zero, clk, rst_n, out_valid && !out_ask_valid,
    out_top_ask == 32'd0, "best ask not zero without an ask")
  `OBT_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && in_ready,
    !in_ready, "second transaction taken while one is in work")
  `OBT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_status), "stalled result changed")

endmodule
bind order_book_best_price_tracker obt_checker u_obt_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_bid_valid(out_bid_valid),
  .out_top_bid(out_top_bid), .out_ask_valid(out_ask_valid),
  .out_top_ask(out_top_ask), .out_status(out_status)
);
`default_nettype wire
